// ===== rtl/core/prime_factorizer_trial_division_defines.svh =====
// Assertion helpers shared by the factorizer RTL.
`ifndef PRIME_FACTORIZER_TRIAL_DIVISION_DEFINES_SVH
`define PRIME_FACTORIZER_TRIAL_DIVISION_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PFT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PFT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pft_pkg.sv =====
package pft_pkg;

  // Default sizing
  localparam int VALUE_BITS_DEF  = 31;
  localparam int STACK_DEPTH_DEF = 32;

  // Largest number of results given for one input
  localparam int MAX_RESULTS = 30;

  // Stack control from the sequencer
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

// ===== rtl/core/pft_div.sv =====
module pft_div #(
  parameter int VALUE_BITS = pft_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quot,
  output logic [VALUE_BITS-1:0] rem
);
  import pft_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] dvs_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;

  // One restoring step: shift in the next dividend bit, trial subtract
  assign shifted = {rem_r, quo_r[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[VALUE_BITS]) begin
        rem_nxt = shifted[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b0};
      end else begin
        rem_nxt = diff[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/pft_stack.sv =====
module pft_stack #(
  parameter int VALUE_BITS  = pft_pkg::VALUE_BITS_DEF,
  parameter int STACK_DEPTH = pft_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pft_pkg::stk_ctrl_t                 ctrl,
  input  logic [VALUE_BITS-1:0]              push_data,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count,
  output logic [VALUE_BITS-1:0]              rd_data
);
  import pft_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CNW = $clog2(STACK_DEPTH + 1);

  logic [VALUE_BITS-1:0] mem [STACK_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [CNW-1:0]        cnt_r, cnt_nxt;
  logic [CNW-1:0]        top_idx;
  logic                  full;

  assign full    = (cnt_r == CNW'(STACK_DEPTH));
  assign top_idx = cnt_r - CNW'(1);

  // Fill count: pushes beyond the depth are dropped
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.clr) begin
      cnt_nxt = '0;
    end else if (ctrl.push && !full) begin
      cnt_nxt = cnt_r + CNW'(1);
    end else if (ctrl.pop) begin
      cnt_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Storage, registered read of the top entry on pop
  always_ff @(posedge clk) begin
    if (ctrl.push && !full && !ctrl.clr) begin
      mem[cnt_r[AW-1:0]] <= push_data;
    end
    if (ctrl.pop) begin
      rd_data_r <= mem[top_idx[AW-1:0]];
    end
  end

  assign count   = cnt_r;
  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/prime_factorizer_trial_division.sv =====
// Trial-division prime factorizer. One number enters on the in_ stream while
// in_tready is high; its prime factors leave on the out_ stream largest first,
// out_tlast on the final one. An input of 0 or 1 gives a single transaction with
// factor 0 and out_tuser (none_found) set. Every trial division runs on one shared
// restoring divider that yields quotient and remainder, and trials continue
// until the divisor passes the square root of the remaining quotient. Factors
// are then popped from a memory stack, each through the pop, pop-wait and output
// states, and held there under any output stall. in_tready stays low from
// acceptance until the last result is taken. Up to STACK_DEPTH factors are kept
// (the largest dropped beyond that) and at most 30 results are given per input.
`include "prime_factorizer_trial_division_defines.svh"

module prime_factorizer_trial_division #(
  parameter int VALUE_BITS  = pft_pkg::VALUE_BITS_DEF,
  parameter int STACK_DEPTH = pft_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    in_tdata,   // value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]    out_tdata,  // factor
  output logic                               out_tlast,
  output logic                               out_tuser   // none_found
);
  import pft_pkg::*;

  localparam int TDW = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CNW = $clog2(STACK_DEPTH + 1);
  localparam int NW  = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DIV_START = 3'd1;
  localparam logic [2:0] S_DIV_WAIT  = 3'd2;
  localparam logic [2:0] S_POP       = 3'd3;
  localparam logic [2:0] S_POP_WAIT  = 3'd4;
  localparam logic [2:0] S_OUT       = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic                  ov_r, ov_nxt;
  logic [VALUE_BITS-1:0] of_r, of_nxt;
  logic                  ol_r, ol_nxt;
  logic                  onf_r, onf_nxt;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [VALUE_BITS-1:0] div_rem;

  stk_ctrl_t             stk_ctrl;
  logic [VALUE_BITS-1:0] stk_push_data;
  logic [CNW-1:0]        stk_count;
  logic [VALUE_BITS-1:0] stk_rd_data;

  logic [VALUE_BITS-1:0] in_value;
  logic                  in_acc;

  assign in_value = in_tdata[VALUE_BITS-1:0];
  assign in_acc   = in_tvalid && in_tready;

  pft_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q_r),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  pft_stack #(.VALUE_BITS(VALUE_BITS), .STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (stk_ctrl),
    .push_data (stk_push_data),
    .count     (stk_count),
    .rd_data   (stk_rd_data)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    d_nxt         = d_r;
    n_nxt         = n_r;
    ov_nxt        = ov_r;
    of_nxt        = of_r;
    ol_nxt        = ol_r;
    onf_nxt       = onf_r;
    div_start     = 1'b0;
    stk_ctrl      = '0;
    stk_push_data = d_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          q_nxt        = in_value;
          d_nxt        = VALUE_BITS'(2);
          n_nxt        = '0;
          stk_ctrl.clr = 1'b1;
          if (in_value <= VALUE_BITS'(1)) begin
            ov_nxt    = 1'b1;
            of_nxt    = '0;
            ol_nxt    = 1'b1;
            onf_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DIV_START;
          end
        end
      end
      S_DIV_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (d_r > div_quot) begin
            // no divisor up to the square root: quotient is prime
            stk_ctrl.push = 1'b1;
            stk_push_data = q_r;
            d_nxt         = q_r;
            q_nxt         = VALUE_BITS'(1);
            state_nxt     = S_POP;
          end else if (div_rem == '0) begin
            stk_ctrl.push = 1'b1;
            stk_push_data = d_r;
            q_nxt         = div_quot;
            state_nxt     = (div_quot == VALUE_BITS'(1)) ? S_POP : S_DIV_START;
          end else begin
            d_nxt     = d_r + VALUE_BITS'(1);
            state_nxt = S_DIV_START;
          end
        end
      end
      S_POP: begin
        stk_ctrl.pop = 1'b1;
        state_nxt    = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        ov_nxt    = 1'b1;
        of_nxt    = stk_rd_data;
        ol_nxt    = (stk_count == '0) || (n_r == NW'(MAX_RESULTS - 1));
        onf_nxt   = 1'b0;
        n_nxt     = n_r + NW'(1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          ov_nxt    = 1'b0;
          state_nxt = ol_r ? S_IDLE : S_POP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      n_r     <= '0;
      q_r     <= '0;
      d_r     <= VALUE_BITS'(2);
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      n_r     <= n_nxt;
      q_r     <= q_nxt;
      d_r     <= d_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    of_r  <= of_nxt;
    ol_r  <= ol_nxt;
    onf_r <= onf_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = TDW'(of_r);
  assign out_tlast  = ol_r;
  assign out_tuser  = onf_r;

  `PFT_ASSERT_IMP(a_one_side_busy, out_tvalid, !in_tready, "input taken while result pending")
  `PFT_ASSERT_IMP(a_none_found_alone, out_tvalid && out_tuser, out_tlast && (of_r == '0),
                  "none_found result must be the only one, with factor zero")
  `PFT_ASSERT_IMP(a_div_done_state, div_done, state_r == S_DIV_WAIT,
                  "divider finished outside a trial")
  `PFT_ASSERT_NXT(a_trivial_input, in_acc && (in_value <= VALUE_BITS'(1)),
                  out_tvalid && out_tuser, "input of 0 or 1 must give none_found")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

localparam int VALUE_BITS  = pft_pkg::VALUE_BITS_DEF;
localparam int STACK_DEPTH = pft_pkg::STACK_DEPTH_DEF;
localparam int TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;

typedef bit [VALUE_BITS-1:0] value_t;

// One factor transaction as it should leave the block
typedef struct {
  value_t factor;
  bit     last;
  bit     none_found;
} factor_result_t;

class factor_scoreboard;
  factor_result_t expected_factors[$];
  value_t         found[$];
  int             errors;

  // Trial division of one value; leaves the emitted factors in found, largest
  // first, and returns the number of trials the search takes.
  function int factorize(value_t value);
    longint unsigned q, d, f;
    value_t          factor_pile [STACK_DEPTH];
    int              depth, trials;
    q = value;
    d = 2;
    depth = 0;
    trials = 0;
    found.delete();
    if (q <= 1) return 0;
    while (q != 1) begin
      trials++;
      f = 0;
      if (d > q / d) begin
        // nothing up to the square root divides it: the rest is prime
        f = q;
        d = q;
        q = 1;
      end else if (q % d == 0) begin
        f = d;
        q = q / d;
      end else begin
        d++;
      end
      // a full pile drops the factor, so the largest ones get lost
      if (f != 0 && depth < STACK_DEPTH) begin
        factor_pile[depth] = value_t'(f);
        depth++;
      end
    end
    while (depth > 0 && found.size() < pft_pkg::MAX_RESULTS) begin
      depth--;
      found.push_back(factor_pile[depth]);
    end
    return trials;
  endfunction

  // Called once per accepted input transaction
  function void note_value(value_t value);
    factor_result_t r;
    void'(factorize(value));
    if (found.size() == 0) begin
      // zero and one both give the single none-found transaction
      r.factor = '0;
      r.last = 1'b1;
      r.none_found = 1'b1;
      expected_factors.push_back(r);
    end else begin
      foreach (found[i]) begin
        r.factor = found[i];
        r.last = (i == found.size() - 1);
        r.none_found = 1'b0;
        expected_factors.push_back(r);
      end
    end
  endfunction

  function void flag(string field, longint unsigned exp_v, longint unsigned act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
  endfunction

  // Called once per accepted output transaction
  function void check_factor(value_t factor, bit last, bit none_found);
    factor_result_t r;
    if (expected_factors.size() == 0) begin
      errors++;
      $display("%0t: unexpected factor %0d, expected nothing, got last %0b none_found %0b",
               $time, factor, last, none_found);
      return;
    end
    r = expected_factors.pop_front();
    if (factor !== r.factor) flag("factor", r.factor, factor);
    if (last !== r.last) flag("last", r.last, last);
    if (none_found !== r.none_found) flag("none_found", r.none_found, none_found);
  endfunction
endclass

module tb_top;

  // Quiet cycles allowed before the run is declared hung
  localparam int WATCHDOG_CYCLES = 300000;
  // Trials allowed for one random value, keeps the run short
  localparam int TRIAL_BUDGET    = 600;
  localparam int RANDOM_ITEMS    = 121;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_BITS-1:0] in_tdata = '0;   // value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_BITS-1:0] out_tdata;       // factor
  logic                  out_tlast;
  logic                  out_tuser;       // none_found

  logic                  no_idle = 1'b0;
  int                    quiet_cycles = 0;
  factor_scoreboard      sb = new();

  prime_factorizer_trial_division dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: random back-pressure, none during the steady stretch
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= 31);
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_factor(out_tdata[VALUE_BITS-1:0], out_tlast, out_tuser);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Product of small random factors below 2**bits: many factors, cheap to search
  function automatic value_t smooth_value(int bits);
    longint unsigned acc, p, ceiling;
    acc = 1;
    ceiling = (64'd1 << bits) - 1;
    for (int k = 0; k < 40; k++) begin
      p = $urandom_range(0, 1) ? $urandom_range(2, 7) : $urandom_range(2, 300);
      if (acc * p <= ceiling) acc = acc * p;
    end
    return value_t'(acc);
  endfunction

  // Random value whose factor search stays within the trial budget
  function automatic value_t pick_value();
    value_t          v;
    int              shape;
    longint unsigned base, scale;
    for (int tries = 0; tries < 100; tries++) begin
      shape = $urandom_range(0, 99);
      if (shape < 25) begin
        v = value_t'($urandom_range(0, 4095));
      end else if (shape < 60) begin
        v = smooth_value($urandom_range(2, VALUE_BITS));
      end else if (shape < 85) begin
        v = value_t'($urandom() >> $urandom_range(1, 30));
      end else begin
        // smooth part times one larger cofactor
        base = smooth_value($urandom_range(2, 16));
        scale = $urandom_range(2, 2000000);
        if (((base * scale) >> VALUE_BITS) != 0) continue;
        v = value_t'(base * scale);
      end
      if (sb.factorize(v) <= TRIAL_BUDGET) return v;
    end
    return smooth_value(VALUE_BITS);
  endfunction

  // Present one value, with an occasional gap first, and wait for the transaction
  task automatic offer_value(input value_t v);
    if (!no_idle && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tdata <= TDATA_BITS'(v);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_value(v);
  endtask

  // Hold off the sender until every pending factor is out
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (sb.expected_factors.size() != 0) @(posedge clk);
  endtask

  initial begin
    value_t directed_values[$];
    // zero, one, tiny primes and composites, a square, two close primes,
    // large primes left as quotient, the most factors, wide bit patterns
    directed_values = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd9,
                        31'd12, 31'd30, 31'd8633, 31'd65521, 31'd999983,
                        31'd1999966, 31'h4000_0000, 31'd1162261467,
                        31'h5555_5555, 31'h7FFF_FFFE, 31'd1047552};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) offer_value(directed_values[i]);
    wait_for_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle <= (n >= 50 && n < 90);
      offer_value(pick_value());
      if ($urandom_range(0, 99) < 5) wait_for_results();
    end

    // Drain, then watch a while for stray transactions
    in_tvalid <= 1'b0;
    while (sb.expected_factors.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_factors.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
